// ===== hdl/sha512_pkg.sv =====
package sha512_pkg;

  localparam int unsigned WordW = 64;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [6:0] LengthAt = 7'd112;
  localparam logic [6:0] LastRound = 7'd79;
  localparam logic [6:0] FinalStep = 7'd80;
  localparam logic [2:0] LastIdx512 = 3'd7;
  localparam logic [2:0] LastIdx384 = 3'd5;

  typedef logic [WordW-1:0] word_t;

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = ror(x, 28) ^ ror(x, 34) ^ ror(x, 39);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = ror(x, 14) ^ ror(x, 18) ^ ror(x, 41);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = ror(x, 1) ^ ror(x, 8) ^ (x >> 7);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = ror(x, 19) ^ ror(x, 61) ^ (x >> 6);
  endfunction

  function automatic word_t init_value(input logic mode, input logic [2:0] idx);
    if (mode) begin
      case (idx)
        3'd0: init_value = 64'hcbbb9d5dc1059ed8;
        3'd1: init_value = 64'h629a292a367cd507;
        3'd2: init_value = 64'h9159015a3070dd17;
        3'd3: init_value = 64'h152fecd8f70e5939;
        3'd4: init_value = 64'h67332667ffc00b31;
        3'd5: init_value = 64'h8eb44a8768581511;
        3'd6: init_value = 64'hdb0c2e0d64f98fa7;
        default: init_value = 64'h47b5481dbefa4fa4;
      endcase
    end else begin
      case (idx)
        3'd0: init_value = 64'h6a09e667f3bcc908;
        3'd1: init_value = 64'hbb67ae8584caa73b;
        3'd2: init_value = 64'h3c6ef372fe94f82b;
        3'd3: init_value = 64'ha54ff53a5f1d36f1;
        3'd4: init_value = 64'h510e527fade682d1;
        3'd5: init_value = 64'h9b05688c2b3e6c1f;
        3'd6: init_value = 64'h1f83d9abfb41bd6b;
        default: init_value = 64'h5be0cd19137e2179;
      endcase
    end
  endfunction

  function automatic word_t round_k(input logic [6:0] t);
    case (t)
      7'd0: round_k = 64'h428a2f98d728ae22;  7'd1: round_k = 64'h7137449123ef65cd;
      7'd2: round_k = 64'hb5c0fbcfec4d3b2f;  7'd3: round_k = 64'he9b5dba58189dbbc;
      7'd4: round_k = 64'h3956c25bf348b538;  7'd5: round_k = 64'h59f111f1b605d019;
      7'd6: round_k = 64'h923f82a4af194f9b;  7'd7: round_k = 64'hab1c5ed5da6d8118;
      7'd8: round_k = 64'hd807aa98a3030242;  7'd9: round_k = 64'h12835b0145706fbe;
      7'd10: round_k = 64'h243185be4ee4b28c; 7'd11: round_k = 64'h550c7dc3d5ffb4e2;
      7'd12: round_k = 64'h72be5d74f27b896f; 7'd13: round_k = 64'h80deb1fe3b1696b1;
      7'd14: round_k = 64'h9bdc06a725c71235; 7'd15: round_k = 64'hc19bf174cf692694;
      7'd16: round_k = 64'he49b69c19ef14ad2; 7'd17: round_k = 64'hefbe4786384f25e3;
      7'd18: round_k = 64'h0fc19dc68b8cd5b5; 7'd19: round_k = 64'h240ca1cc77ac9c65;
      7'd20: round_k = 64'h2de92c6f592b0275; 7'd21: round_k = 64'h4a7484aa6ea6e483;
      7'd22: round_k = 64'h5cb0a9dcbd41fbd4; 7'd23: round_k = 64'h76f988da831153b5;
      7'd24: round_k = 64'h983e5152ee66dfab; 7'd25: round_k = 64'ha831c66d2db43210;
      7'd26: round_k = 64'hb00327c898fb213f; 7'd27: round_k = 64'hbf597fc7beef0ee4;
      7'd28: round_k = 64'hc6e00bf33da88fc2; 7'd29: round_k = 64'hd5a79147930aa725;
      7'd30: round_k = 64'h06ca6351e003826f; 7'd31: round_k = 64'h142929670a0e6e70;
      7'd32: round_k = 64'h27b70a8546d22ffc; 7'd33: round_k = 64'h2e1b21385c26c926;
      7'd34: round_k = 64'h4d2c6dfc5ac42aed; 7'd35: round_k = 64'h53380d139d95b3df;
      7'd36: round_k = 64'h650a73548baf63de; 7'd37: round_k = 64'h766a0abb3c77b2a8;
      7'd38: round_k = 64'h81c2c92e47edaee6; 7'd39: round_k = 64'h92722c851482353b;
      7'd40: round_k = 64'ha2bfe8a14cf10364; 7'd41: round_k = 64'ha81a664bbc423001;
      7'd42: round_k = 64'hc24b8b70d0f89791; 7'd43: round_k = 64'hc76c51a30654be30;
      7'd44: round_k = 64'hd192e819d6ef5218; 7'd45: round_k = 64'hd69906245565a910;
      7'd46: round_k = 64'hf40e35855771202a; 7'd47: round_k = 64'h106aa07032bbd1b8;
      7'd48: round_k = 64'h19a4c116b8d2d0c8; 7'd49: round_k = 64'h1e376c085141ab53;
      7'd50: round_k = 64'h2748774cdf8eeb99; 7'd51: round_k = 64'h34b0bcb5e19b48a8;
      7'd52: round_k = 64'h391c0cb3c5c95a63; 7'd53: round_k = 64'h4ed8aa4ae3418acb;
      7'd54: round_k = 64'h5b9cca4f7763e373; 7'd55: round_k = 64'h682e6ff3d6b2b8a3;
      7'd56: round_k = 64'h748f82ee5defb2fc; 7'd57: round_k = 64'h78a5636f43172f60;
      7'd58: round_k = 64'h84c87814a1f0ab72; 7'd59: round_k = 64'h8cc702081a6439ec;
      7'd60: round_k = 64'h90befffa23631e28; 7'd61: round_k = 64'ha4506cebde82bde9;
      7'd62: round_k = 64'hbef9a3f7b2c67915; 7'd63: round_k = 64'hc67178f2e372532b;
      7'd64: round_k = 64'hca273eceea26619c; 7'd65: round_k = 64'hd186b8c721c0c207;
      7'd66: round_k = 64'heada7dd6cde0eb1e; 7'd67: round_k = 64'hf57d4f7fee6ed178;
      7'd68: round_k = 64'h06f067aa72176fba; 7'd69: round_k = 64'h0a637dc5a2c898a6;
      7'd70: round_k = 64'h113f9804bef90dae; 7'd71: round_k = 64'h1b710b35131c471b;
      7'd72: round_k = 64'h28db77f523047d84; 7'd73: round_k = 64'h32caab7b40c72493;
      7'd74: round_k = 64'h3c9ebe0a15c9bebc; 7'd75: round_k = 64'h431d67c49c100d4c;
      7'd76: round_k = 64'h4cc5d4becb3e42b6; 7'd77: round_k = 64'h597f299cfc657e2a;
      7'd78: round_k = 64'h5fcb6fab3ad6faec; 7'd79: round_k = 64'h6c44198c4a475817;
      default: round_k = '0;
    endcase
  endfunction

endpackage

// ===== hdl/sha512_sha384_hash_engine.sv =====
// Channel   Handshake              Payload
// input     in_valid / in_stall    msg_word, valid_bytes, end_of_message
// output    out_valid / out_stall  digest_word, digest_last
// config    digest_mode_we         digest_mode
//
// Each accepted word is packed into the block buffer one byte at a time through
// a single byte lane before the next word is accepted.
// Every full 128-byte block is then compressed: 80 rounds on the one shared round
// unit and a final step to fold the working variables into the hash words.
// A last word adds one byte step per padding byte (up to 128, one or two blocks),
// a step to write the bit length, the compression of the final block and then
// the 8 or 6 digest words, one per cycle when not stalled.
// Reset is synchronous and active high; it selects SHA-512 and clears the counters.
// The output holds its word under stall; no input word is taken until the digest
// has been fully delivered.
module sha512_sha384_hash_engine
  import sha512_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] msg_word,
  input  logic [3:0]  valid_bytes,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] digest_word,
  output logic        digest_last,
  input  logic        digest_mode_we,
  input  logic        digest_mode
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_PAD  = 3'd2;
  localparam logic [2:0] S_ZERO = 3'd3;
  localparam logic [2:0] S_COMP = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state;
  logic [2:0]  ret_state;
  logic        mode;
  word_t       hash [8];
  word_t       v [8];
  word_t       block_store [16];
  logic [6:0]  fill_position;
  logic [63:0] message_bytes;
  logic [63:0] word_buf;
  logic [3:0]  bytes_left;
  logic        eom;
  logic [6:0]  rnd;
  logic [2:0]  out_idx;

  logic        put_en;
  logic [7:0]  put_val;
  logic [2:0]  state_next;
  logic        len_en;
  logic        last_word;
  word_t       t1;
  word_t       t2;
  word_t       w_new;

  assign in_stall    = (state != S_IDLE) | digest_mode_we;
  assign out_valid   = (state == S_OUT);
  assign digest_word = hash[out_idx];
  assign last_word   = (out_idx == (mode ? LastIdx384 : LastIdx512));
  assign digest_last = last_word;

  // Byte-level packing control: which byte goes in next and where we go after it.
  always_comb begin
    put_en     = 1'b0;
    put_val    = word_buf[63:56];
    state_next = state;
    len_en     = 1'b0;
    unique case (state)
      S_INS: begin
        if (bytes_left != 4'd0) begin
          put_en     = 1'b1;
          state_next = S_INS;
        end else begin
          state_next = eom ? S_PAD : S_IDLE;
        end
      end
      S_PAD: begin
        put_en     = 1'b1;
        put_val    = PadByte;
        state_next = S_ZERO;
      end
      S_ZERO: begin
        if (fill_position == LengthAt) begin
          len_en = 1'b1;
        end else begin
          put_en     = 1'b1;
          put_val    = 8'h00;
          state_next = S_ZERO;
        end
      end
      default: ;
    endcase
  end

  // One SHA-512 round and one message schedule step.
  assign t1 = v[7] + big_sigma1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + round_k(rnd) + block_store[0];
  assign t2 = big_sigma0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  assign w_new = block_store[0] + small_sigma0(block_store[1]) + block_store[9]
               + small_sigma1(block_store[14]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ret_state     <= S_IDLE;
      mode          <= 1'b0;
      fill_position <= '0;
      message_bytes <= '0;
      bytes_left    <= '0;
      eom           <= 1'b0;
      rnd           <= '0;
      out_idx       <= '0;
      for (int i = 0; i < 8; i++) hash[i] <= init_value(1'b0, 3'(i));
    end else begin
      unique case (state)
        S_IDLE: begin
          if (digest_mode_we) begin
            mode          <= digest_mode;
            fill_position <= '0;
            message_bytes <= '0;
            for (int i = 0; i < 8; i++) hash[i] <= init_value(digest_mode, 3'(i));
          end else if (in_valid) begin
            word_buf   <= msg_word;
            bytes_left <= (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
            eom        <= end_of_message;
            state      <= S_INS;
          end
        end
        S_INS, S_PAD, S_ZERO: begin
          if (put_en) begin
            for (int l = 0; l < 8; l++) begin
              if (fill_position[2:0] == 3'(l)) begin
                block_store[fill_position[6:3]][63-8*l -: 8] <= put_val;
              end
            end
            if (state == S_INS) begin
              message_bytes <= message_bytes + 64'd1;
              bytes_left    <= bytes_left - 4'd1;
              word_buf      <= {word_buf[55:0], 8'h00};
            end
            if (fill_position == 7'd127) begin
              fill_position <= '0;
              ret_state     <= state_next;
              state         <= S_COMP;
              rnd           <= '0;
              for (int i = 0; i < 8; i++) v[i] <= hash[i];
            end else begin
              fill_position <= fill_position + 7'd1;
              state         <= state_next;
            end
          end else if (len_en) begin
            // The 128-bit bit length closes the final block.
            block_store[14] <= {61'd0, message_bytes[63:61]};
            block_store[15] <= {message_bytes[60:0], 3'b000};
            ret_state       <= S_OUT;
            state           <= S_COMP;
            rnd             <= '0;
            out_idx         <= '0;
            for (int i = 0; i < 8; i++) v[i] <= hash[i];
          end else begin
            state <= state_next;
          end
        end
        S_COMP: begin
          if (rnd == FinalStep) begin
            for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
            state <= ret_state;
          end else begin
            v[7] <= v[6];
            v[6] <= v[5];
            v[5] <= v[4];
            v[4] <= v[3] + t1;
            v[3] <= v[2];
            v[2] <= v[1];
            v[1] <= v[0];
            v[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) block_store[i] <= block_store[i+1];
            block_store[15] <= w_new;
            rnd <= rnd + 7'd1;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            if (last_word) begin
              out_idx       <= '0;
              fill_position <= '0;
              message_bytes <= '0;
              for (int i = 0; i < 8; i++) hash[i] <= init_value(mode, 3'(i));
              state <= S_IDLE;
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/sha512_chk.sv =====
module sha512_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] digest_word,
  input logic        digest_last
);

  // No new word is taken while a digest is being delivered.
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input accepted during digest output");

  // A word, once taken, keeps the engine busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("engine ready straight after a word");

  // The run ends after its last digest word is delivered.
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && digest_last) |=> !out_valid)
    else $error("output continued after the last digest word");

  // A stalled digest word holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(digest_word)))
    else $error("digest word changed under stall");

endmodule

bind sha512_sha384_hash_engine sha512_chk u_sha512_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .digest_word(digest_word),
  .digest_last(digest_last)
);

// ===== dv/sha512_sha384_hash_engine_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the SHA-512 / SHA-384 engine. Message words go in
// through the input channel. A scoreboard object runs its own byte-level hash
// predictor on every accepted word and queues the digest words that a last word
// must produce. The output channel is compared word by word against that queue.
module sha512_sha384_hash_engine_tb;
  import sha512_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned SettleCycles = 300;
  localparam int unsigned HoldCycles = 400;
  localparam logic ModeSha512 = 1'b0;
  localparam logic ModeSha384 = 1'b1;

  typedef struct packed {
    word_t word;
    logic  last;
  } digest_beat_t;

  // The scoreboard keeps its own copy of the hash state and the selected mode.
  // It is told about every accepted word and about every mode write.
  class digest_scoreboard;
    word_t        hash_state[8];
    word_t        block_buf[16];
    int unsigned  fill_at;
    logic [63:0]  msg_len_bytes;
    logic         sha384_sel;
    int unsigned  mismatches;
    digest_beat_t pending_digest[$];

    function new();
      mismatches = 0;
      foreach (block_buf[i]) block_buf[i] = '0;
      select_mode(ModeSha512);
    endfunction

    function word_t rotr(word_t x, int unsigned n);
      return (x >> n) | (x << (64 - n));
    endfunction

    function word_t start_value(int unsigned i);
      word_t iv512[8] = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
                          64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
                          64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
                          64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
      word_t iv384[8] = '{64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507,
                          64'h9159015a3070dd17, 64'h152fecd8f70e5939,
                          64'h67332667ffc00b31, 64'h8eb44a8768581511,
                          64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};
      return sha384_sel ? iv384[i] : iv512[i];
    endfunction

    // A mode write abandons any message in progress.
    function void select_mode(logic m);
      sha384_sel = m;
      restart();
    endfunction

    function void restart();
      foreach (hash_state[i]) hash_state[i] = start_value(i);
      fill_at = 0;
      msg_len_bytes = '0;
    endfunction

    function void compress_block();
      word_t ks[80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
      word_t sched[80];
      word_t v[8];
      word_t t1, t2;
      for (int t = 0; t < 80; t++) begin
        if (t < 16) begin
          sched[t] = block_buf[t];
        end else begin
          sched[t] = sched[t-16] + sched[t-7]
                   + (rotr(sched[t-15], 1) ^ rotr(sched[t-15], 8) ^ (sched[t-15] >> 7))
                   + (rotr(sched[t-2], 19) ^ rotr(sched[t-2], 61) ^ (sched[t-2] >> 6));
        end
      end
      v = hash_state;
      for (int t = 0; t < 80; t++) begin
        t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ks[t] + sched[t];
        t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      foreach (hash_state[i]) hash_state[i] += v[i];
    endfunction

    function void append_byte(logic [7:0] b);
      int unsigned sh;
      sh = 56 - 8 * (fill_at % 8);
      block_buf[fill_at / 8] = (block_buf[fill_at / 8] & ~(64'hff << sh))
                             | (word_t'(b) << sh);
      fill_at++;
      if (fill_at == 128) begin
        compress_block();
        fill_at = 0;
      end
    endfunction

    function void note_word(word_t w, logic [3:0] nbytes, logic eom);
      int unsigned take, count;
      take = (nbytes > 8) ? 8 : nbytes;
      for (int i = 0; i < take; i++) begin
        append_byte(w[63 - 8 * i -: 8]);
        msg_len_bytes++;
      end
      if (!eom) return;
      append_byte(8'h80);
      if (fill_at > 112) begin
        while (fill_at != 0) append_byte(8'h00);
      end
      while (fill_at < 112) append_byte(8'h00);
      block_buf[14] = msg_len_bytes >> 61;
      block_buf[15] = msg_len_bytes << 3;
      compress_block();
      count = sha384_sel ? 6 : 8;
      for (int i = 0; i < count; i++) begin
        pending_digest.push_back('{word: hash_state[i], last: (i + 1 == count)});
      end
      restart();
    endfunction

    function void check_digest(word_t w, logic last);
      digest_beat_t exp_beat;
      if (pending_digest.size() == 0) begin
        $error("digest word %h arrived with none expected", w);
        mismatches++;
        return;
      end
      exp_beat = pending_digest.pop_front();
      if (w !== exp_beat.word) begin
        $error("digest_word: expected %h, got %h", exp_beat.word, w);
        mismatches++;
      end
      if (last !== exp_beat.last) begin
        $error("digest_last: expected %b, got %b", exp_beat.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] msg_word = '0;
  logic [3:0]  valid_bytes = '0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] digest_word;
  logic        digest_last;
  logic        digest_mode_we = 1'b0;
  logic        digest_mode = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned words_sent = 0;
  int unsigned hold_left = 0;
  logic        hold_start = 1'b0;
  int unsigned cycle_count = 0;

  digest_scoreboard sb = new();

  sha512_sha384_hash_engine dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .msg_word       (msg_word),
    .valid_bytes    (valid_bytes),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .digest_word    (digest_word),
    .digest_last    (digest_last),
    .digest_mode_we (digest_mode_we),
    .digest_mode    (digest_mode)
  );

  always #2 clk = ~clk;

  // The watchdog ends a run that hangs, for instance when a digest never comes.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The long hold-off is counted here, apart from the random stalls, so that
  // the engine backs up with a digest waiting and stops taking input.
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= HoldCycles;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: a digest word is taken on any edge where it is valid and not
  // stalled. Values read here are the ones present at the edge itself.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_digest(digest_word, digest_last);
    end
    out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
  end

  // Offers one word, with random idle cycles in front, and waits until it is
  // accepted. The payload is held unchanged for as long as the engine stalls.
  task automatic send_word(word_t w, logic [3:0] nbytes, logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    msg_word       <= w;
    valid_bytes    <= nbytes;
    end_of_message <= eom;
    do @(posedge clk); while (in_stall);
    sb.note_word(w, nbytes, eom);
    words_sent++;
  endtask

  function automatic word_t random_word();
    return {$urandom, $urandom};
  endfunction

  // A message of full words with random content. Now and then a short word
  // sits in the middle, or a byte count above eight, which counts as eight.
  task automatic send_message(int unsigned nwords);
    logic [3:0] nbytes;
    for (int i = 0; i < nwords; i++) begin
      case ($urandom_range(19))
        0, 1:    nbytes = 4'($urandom_range(7));
        2:       nbytes = 4'($urandom_range(15, 9));
        default: nbytes = 4'd8;
      endcase
      send_word(random_word(), nbytes, 1'b0);
    end
    send_word(random_word(), 4'($urandom_range(15)), 1'b1);
  endtask

  // Lets the engine go quiet: every digest delivered, then a margin for any
  // block compression still running behind an unfinished message.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_digest.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    digest_mode_we <= 1'b1;
    digest_mode    <= m;
    @(posedge clk);
    digest_mode_we <= 1'b0;
    sb.select_mode(m);
  endtask

  task automatic random_phase(int unsigned n_words);
    int unsigned target;
    int unsigned len;
    target = words_sent + n_words;
    while (words_sent < target) begin
      // Mostly short messages; some land right on the pad and block borders.
      case ($urandom_range(9))
        0:       len = $urandom_range(17, 13);
        1:       len = $urandom_range(40, 20);
        default: len = $urandom_range(6);
      endcase
      send_message(len);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 8;
    recv_idle_pct = 88;

    // Directed part, SHA-512 first. The empty message comes first.
    write_mode(ModeSha512);
    send_word('0, 4'd0, 1'b1);
    // A three-byte message; the unused low bytes must be ignored.
    send_word(64'h616263ffffffffff, 4'd3, 1'b1);
    // 112 bytes: the pad byte lands on the length field, forcing a second block.
    for (int i = 0; i < 14; i++) send_word(~word_t'(i), 4'd8, 1'b0);
    send_word('1, 4'd0, 1'b1);
    // Over-long byte counts at both ends, with a short word in mid-message.
    send_word('1, 4'd15, 1'b0);
    send_word(64'h0123456789abcdef, 4'd5, 1'b0);
    send_word('0, 4'd9, 1'b1);
    drain();

    write_mode(ModeSha384);
    send_word('1, 4'd8, 1'b1);
    send_word('0, 4'd0, 1'b1);
    random_phase(60);
    drain();

    // A mode write abandons a half-sent message; the next word starts afresh.
    send_idle_pct = 88;
    recv_idle_pct = 8;
    for (int i = 0; i < 3; i++) send_word(random_word(), 4'd8, 1'b0);
    drain();
    write_mode(ModeSha512);
    random_phase(60);
    drain();

    // No idling, and a long receiver hold-off so that the engine fills up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_mode(ModeSha384);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    random_phase(30);
    drain();
    write_mode(ModeSha512);
    random_phase(30);
    drain();

    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
